>>> src/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared widths, operation and status codes, and the response record of the
// generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

   localparam int FUNC_W    = 3;
   localparam int HANDLE_W  = 32;
   localparam int PAYLOAD_W = 32;
   localparam int TRK_W     = 9;
   localparam int STATUS_W  = 3;
   localparam int CFG_W     = 8;

   // smallest table size, and the size requested at reset
   localparam int MIN_SIZE   = 3;
   localparam int RESET_SIZE = 255;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_ALLOC      = 3'd0;
   localparam logic [FUNC_W-1:0] FN_LOOKUP     = 3'd1;
   localparam logic [FUNC_W-1:0] FN_RELEASE    = 3'd2;
   localparam logic [FUNC_W-1:0] FN_SCAN_FIRST = 3'd3;
   localparam logic [FUNC_W-1:0] FN_SCAN_NEXT  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ID     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CLOSED     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_STALE      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LIST_EMPTY = 3'd4;
   localparam logic [STATUS_W-1:0] ST_PAST_END   = 3'd5;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [HANDLE_W-1:0]  handle_out;
      logic [PAYLOAD_W-1:0] payload_out;
      logic [TRK_W-1:0]     tracker_out;
      logic                 found;
   } rsp_type;

endpackage

>>> src/ght_if.sv
// ----------------------------------------------------------------------------
// ght_req_if / ght_rsp_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface ght_req_if import ght_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [HANDLE_W-1:0]  handle;
   logic [PAYLOAD_W-1:0] payload_in;
   logic [TRK_W-1:0]     tracker_in;

   modport source (output valid, func, handle, payload_in, tracker_in, input ready);
   modport sink   (input valid, func, handle, payload_in, tracker_in, output ready);
endinterface

interface ght_rsp_if import ght_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [HANDLE_W-1:0]  handle_out;
   logic [PAYLOAD_W-1:0] payload_out;
   logic [TRK_W-1:0]     tracker_out;
   logic                 found;

   modport source (output valid, status, handle_out, payload_out, tracker_out, found,
                   input ready);
   modport sink   (input valid, status, handle_out, payload_out, tracker_out, found,
                   output ready);
endinterface

>>> src/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ght_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ght_rsp_buf.sv
// ----------------------------------------------------------------------------
// ght_rsp_buf
// Two-entry response queue; the head entry drives the response channel.
// ----------------------------------------------------------------------------
module ght_rsp_buf import ght_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rsp_type    push_data,
   output logic       room,
   ght_rsp_if.source  rsp
);

   localparam logic [1:0] CNT_FULL = 2'd2;

   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop  = rsp.valid && rsp.ready;
   assign room = (cnt_ff != CNT_FULL);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
      case (cnt_ff)
         2'd0: begin
            if (push) head_in = push_data;
         end
         2'd1: begin
            if (push && pop) head_in = push_data;
            else if (push)   tail_in = push_data;
         end
         2'd2: begin
            if (pop) head_in = tail_ff;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp.valid       = (cnt_ff != 2'd0);
   assign rsp.status      = head_ff.status;
   assign rsp.handle_out  = head_ff.handle_out;
   assign rsp.payload_out = head_ff.payload_out;
   assign rsp.tracker_out = head_ff.tracker_out;
   assign rsp.found       = head_ff.found;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != CNT_FULL))
      else $error("response pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |=> (cnt_ff == 2'd0 || $past(push)))
      else $error("response count rose without a push");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("response count out of range");

endmodule

>>> src/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Slot table with generational handles and a LIFO free list. Per-slot
// open bit, age and free-list link live in one RAM, payload words in another.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | contents
//  ---------+-----+------------------+-----------------------------------------
//  req_ch   | in  | valid/ready      | func, handle, payload_in, tracker_in
//  rsp_ch   | out | valid/ready      | status, handle_out, payload_out,
//           |     |                  | tracker_out, found
//  csr_*    | in  | write enable     | table_size (8 bits), no read-back
//
//  Allocate, lookup and release do a RAM read, then a check and write-back.
//  Requests rejected on index or an empty free list answer in the accept
//  cycle. Scans read one slot per cycle through the meta RAM read port.
//  After reset and after every table_size write a clearing pass rewrites
//  the meta RAM, one slot a cycle, over table_size slots (255 after reset);
//  requests are held off meanwhile.
//  A two-entry response queue lets the next request in while a response
//  still waits on rsp_ch.
// ----------------------------------------------------------------------------
module generational_handle_table_top import ght_pkg::*; #(
   parameter int INDEX_BITS  = 8,
   parameter int TABLE_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   ght_req_if.sink          req_ch,
   ght_rsp_if.source        rsp_ch
);

   // address width of the slot RAMs, age field width, meta word width
   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int AGEW  = 31 - INDEX_BITS;
   localparam int MW    = 1 + AGEW + AW;
   // largest usable table size: index all-ones is reserved, RAM depth caps it
   localparam int IDX_CAP  = (1 << INDEX_BITS) - 1;
   localparam int CAP      = (IDX_CAP < TABLE_DEPTH) ? IDX_CAP : TABLE_DEPTH;
   localparam int RST_SIZE = (RESET_SIZE > CAP) ? CAP : RESET_SIZE;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_RMW   = 2'd2;
   localparam logic [1:0] S_SCAN  = 2'd3;

   // control state
   logic [1:0]       state_ff, state_in;
   logic [TRK_W-1:0] size_ff, size_in;
   logic [AW-1:0]    free_head_ff, free_head_in;
   logic             free_empty_ff, free_empty_in;
   logic [TRK_W-1:0] clr_ptr_ff, clr_ptr_in;

   // per-transaction holding registers
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [HANDLE_W-1:0]  handle_ff, handle_in;
   logic [PAYLOAD_W-1:0] pin_ff, pin_in;
   logic [AW-1:0]        slot_ff, slot_in;
   logic [TRK_W-1:0]     scan_ptr_ff, scan_ptr_in;
   logic [TRK_W-1:0]     rd_idx_ff, rd_idx_in;

   // RAM ports
   logic [AW-1:0]        rd_addr;
   logic                 meta_we;
   logic [AW-1:0]        meta_waddr;
   logic [MW-1:0]        meta_wdata;
   logic [MW-1:0]        meta_rd;
   logic                 pay_we;
   logic [PAYLOAD_W-1:0] pay_rd;

   logic            rd_open;
   logic [AGEW-1:0] rd_age;
   logic [AW-1:0]   rd_next;

   logic             req_acc;
   logic             buf_room;
   logic             res_push;
   rsp_type          res_data;
   logic [TRK_W-1:0] csr_size;
   logic [TRK_W-1:0] clr_nxt;
   logic [TRK_W-1:0] rd_idx_nxt;
   logic             idx_bad;

   assign rd_open = meta_rd[MW-1];
   assign rd_age  = meta_rd[AW +: AGEW];
   assign rd_next = meta_rd[AW-1:0];

   assign req_ch.ready = (state_ff == S_IDLE) && !csr_wr_en && buf_room;
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign clr_nxt    = clr_ptr_ff + 1'b1;
   assign rd_idx_nxt = rd_idx_ff + 1'b1;
   // index out of the table, or the all-ones handle
   assign idx_bad = (32'(req_ch.handle[INDEX_BITS-1:0]) >= 32'(size_ff)) ||
                    (req_ch.handle == '1);

   // table_size write: raise to the minimum, cap at the usable size
   always_comb begin
      csr_size = TRK_W'(csr_wr_data);
      if (csr_size < TRK_W'(MIN_SIZE)) csr_size = TRK_W'(MIN_SIZE);
      if (32'(csr_size) > CAP)         csr_size = TRK_W'(CAP);
   end

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      free_head_in  = free_head_ff;
      free_empty_in = free_empty_ff;
      clr_ptr_in    = clr_ptr_ff;
      func_in       = func_ff;
      handle_in     = handle_ff;
      pin_in        = pin_ff;
      slot_in       = slot_ff;
      scan_ptr_in   = scan_ptr_ff;
      rd_idx_in     = rd_idx_ff;
      rd_addr       = '0;
      meta_we       = 1'b0;
      meta_waddr    = slot_ff;
      meta_wdata    = '0;
      pay_we        = 1'b0;
      res_push      = 1'b0;
      res_data      = '0;

      case (state_ff)
         S_CLEAR: begin
            // closed, age zero, linked to the next slot; the last links to itself
            meta_we    = 1'b1;
            meta_waddr = AW'(clr_ptr_ff);
            meta_wdata = {1'b0, AGEW'(0),
                          AW'((clr_nxt < size_ff) ? clr_nxt : clr_ptr_ff)};
            clr_ptr_in = clr_nxt;
            if (clr_nxt >= size_ff) state_in = S_IDLE;
         end

         S_IDLE: begin
            if (req_acc) begin
               func_in   = req_ch.func;
               handle_in = req_ch.handle;
               pin_in    = req_ch.payload_in;
               case (req_ch.func)
                  FN_ALLOC: begin
                     if (free_empty_ff) begin
                        res_push            = 1'b1;
                        res_data.status     = ST_LIST_EMPTY;
                        res_data.handle_out = '1;
                     end else begin
                        rd_addr  = free_head_ff;
                        slot_in  = free_head_ff;
                        state_in = S_RMW;
                     end
                  end
                  FN_LOOKUP, FN_RELEASE: begin
                     if (idx_bad) begin
                        res_push        = 1'b1;
                        res_data.status = ST_BAD_ID;
                     end else begin
                        rd_addr  = AW'(req_ch.handle[INDEX_BITS-1:0]);
                        slot_in  = AW'(req_ch.handle[INDEX_BITS-1:0]);
                        state_in = S_RMW;
                     end
                  end
                  FN_SCAN_FIRST: begin
                     rd_addr     = '0;
                     rd_idx_in   = '0;
                     scan_ptr_in = TRK_W'(1);
                     state_in    = S_SCAN;
                  end
                  FN_SCAN_NEXT: begin
                     if (req_ch.tracker_in > size_ff) begin
                        res_push             = 1'b1;
                        res_data.status      = ST_PAST_END;
                        res_data.tracker_out = req_ch.tracker_in;
                     end else if (req_ch.tracker_in == size_ff) begin
                        res_push             = 1'b1;
                        res_data.tracker_out = req_ch.tracker_in + 1'b1;
                     end else begin
                        rd_addr     = AW'(req_ch.tracker_in);
                        rd_idx_in   = req_ch.tracker_in;
                        scan_ptr_in = req_ch.tracker_in + 1'b1;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                     res_push        = 1'b1;
                     res_data.status = ST_BAD_ID;
                  end
               endcase
            end
         end

         S_RMW: begin
            res_push = 1'b1;
            state_in = S_IDLE;
            case (func_ff)
               FN_ALLOC: begin
                  // pop the free list; a self link marks its last slot
                  if (rd_next == slot_ff) free_empty_in = 1'b1;
                  else                    free_head_in  = rd_next;
                  meta_we    = 1'b1;
                  meta_wdata = {1'b1, rd_age, rd_next};
                  pay_we     = 1'b1;
                  res_data.handle_out = {1'b1, rd_age, INDEX_BITS'(slot_ff)};
               end
               FN_LOOKUP, FN_RELEASE: begin
                  if (!rd_open) begin
                     res_data.status = ST_CLOSED;
                  end else if (!handle_ff[HANDLE_W-1] ||
                               rd_age != handle_ff[HANDLE_W-2:INDEX_BITS]) begin
                     res_data.status = ST_STALE;
                  end else begin
                     res_data.payload_out = pay_rd;
                     if (func_ff == FN_RELEASE) begin
                        // close, bump the age, push onto the free list
                        meta_we       = 1'b1;
                        meta_wdata    = {1'b0, rd_age + 1'b1,
                                         free_empty_ff ? slot_ff : free_head_ff};
                        free_head_in  = slot_ff;
                        free_empty_in = 1'b0;
                     end
                  end
               end
               default: begin
                  res_data.status = ST_BAD_ID;
               end
            endcase
         end

         S_SCAN: begin
            // one read issued per cycle; data for rd_idx_ff is checked now
            rd_addr     = AW'(scan_ptr_ff);
            scan_ptr_in = scan_ptr_ff + 1'b1;
            rd_idx_in   = scan_ptr_ff;
            if (rd_open) begin
               res_push = 1'b1;
               state_in = S_IDLE;
               if (func_ff == FN_SCAN_FIRST) begin
                  res_data.tracker_out = rd_idx_ff;
               end else begin
                  res_data.handle_out  = {1'b1, rd_age, INDEX_BITS'(rd_idx_ff)};
                  res_data.payload_out = pay_rd;
                  res_data.tracker_out = rd_idx_nxt;
                  res_data.found       = 1'b1;
               end
            end else if (rd_idx_nxt >= size_ff) begin
               res_push             = 1'b1;
               res_data.tracker_out = size_ff;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase

      // table_size write rebuilds the table
      if (csr_wr_en) begin
         size_in       = csr_size;
         free_head_in  = '0;
         free_empty_in = 1'b0;
         clr_ptr_in    = '0;
         state_in      = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         size_ff       <= TRK_W'(RST_SIZE);
         free_head_ff  <= '0;
         free_empty_ff <= 1'b0;
         clr_ptr_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         free_head_ff  <= free_head_in;
         free_empty_ff <= free_empty_in;
         clr_ptr_ff    <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      handle_ff   <= handle_in;
      pin_ff      <= pin_in;
      slot_ff     <= slot_in;
      scan_ptr_ff <= scan_ptr_in;
      rd_idx_ff   <= rd_idx_in;
   end

   // open bit, age, free-list link
   ght_ram #(
      .WIDTH (MW),
      .DEPTH (TABLE_DEPTH)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (rd_addr),
      .rd_data (meta_rd)
   );

   // payload words, written on allocate only
   ght_ram #(
      .WIDTH (PAYLOAD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (slot_ff),
      .wr_data (pin_ff),
      .rd_addr (rd_addr),
      .rd_data (pay_rd)
   );

   ght_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .room      (buf_room),
      .rsp       (rsp_ch)
   );

   a_rmw_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW) |-> res_push)
      else $error("read-modify-write cycle without a response");

   a_rmw_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW && !csr_wr_en) |=> (state_ff == S_IDLE))
      else $error("read-modify-write did not return to idle");

   a_alloc_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW && func_ff == FN_ALLOC) |-> !free_empty_ff)
      else $error("pop from an empty free list");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (rd_idx_ff < size_ff))
      else $error("scan checked a slot beyond the table");

   a_clear_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (clr_ptr_ff < size_ff))
      else $error("clearing pass beyond the table");

endmodule

>>> tb/generational_handle_table_top_tb.sv
// ----------------------------------------------------------------------------
// generational_handle_table_top_tb
// Self-checking bench for the handle table. A short directed table walks the
// corner cases (fresh handles, bad index, closed and stale handles, empty
// free list, scan boundaries), then randomized phases at several table sizes
// mix well-formed allocate/lookup/release/scan traffic with malformed
// requests. Every response is compared against its directed row's typed answer or a predictor of the table.
// ----------------------------------------------------------------------------
module generational_handle_table_top_tb import ght_pkg::*; ();

   localparam int IDX_W           = 8;
   localparam int DEPTH           = 256;
   localparam int N_PHASES        = 8;
   localparam int ITEMS_PER_PHASE = 220;
   localparam int IDLE_PAUSE      = 300;   // longest scan or clearing pass, with margin
   localparam int SETTLE_CYCLES   = 300;
   localparam int LONG_HOLD       = 400;   // receiver hold-off, in cycles
   localparam int TIMEOUT         = 12_000_000;

   // func codes the block does not implement
   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

   typedef enum logic {ROW_OP, ROW_SIZE} row_kind_type;

   // one line of the directed table; golden is used only when typed is set
   typedef struct {
      row_kind_type         kind;
      logic [FUNC_W-1:0]    func;
      logic [HANDLE_W-1:0]  handle;
      logic [PAYLOAD_W-1:0] payload;
      logic [TRK_W-1:0]     tracker;
      logic [CFG_W-1:0]     size_val;
      bit                   typed;
      rsp_type              golden;
   } dir_row_type;

   typedef struct {
      bit      typed;
      rsp_type rsp;
   } rsp_tag_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   ght_req_if req_if ();
   ght_rsp_if rsp_if ();

   generational_handle_table_top #(
      .INDEX_BITS  (IDX_W),
      .TABLE_DEPTH (DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if)
   );

   // -------------------------------------------------------------------------
   // Predicted table state: id word (open bit, age, index), payload, free link
   // -------------------------------------------------------------------------
   int                   tbl_size;
   logic [HANDLE_W-1:0]  m_id      [DEPTH];
   logic [PAYLOAD_W-1:0] m_payload [DEPTH];
   logic [IDX_W-1:0]     m_link    [DEPTH];
   logic [IDX_W-1:0]     m_free_head;
   bit                   m_free_empty;

   rsp_type     pending_rsp_q [$];   // expected responses, oldest first
   rsp_tag_type table_rsp_q   [$];   // one per offered transaction, typed answer if any
   logic [HANDLE_W-1:0] retired_q [$];   // released handles, reused as stale/closed

   int  fail_count    = 0;
   int  burst_left    = 0;
   int  gapless       = 0;
   bit  long_hold_req = 1'b0;

   // Size write: clamp, then every slot closed at age zero, free list 0..size-1
   function automatic void rebuild_table(input int req);
      int sz;
      sz = req;
      if (sz < MIN_SIZE) sz = MIN_SIZE;
      if (sz > (1 << IDX_W) - 1) sz = (1 << IDX_W) - 1;
      if (sz > DEPTH) sz = DEPTH;
      tbl_size = sz;
      for (int i = 0; i < DEPTH; i++) begin
         m_id[i]      = HANDLE_W'(i % (1 << IDX_W));
         m_payload[i] = '0;
         m_link[i]    = (i + 1 < sz) ? IDX_W'(i + 1) : IDX_W'(i);
      end
      m_free_head  = '0;
      m_free_empty = 1'b0;
   endfunction

   // Handle check order: bad index / all ones, then closed, then stale age
   function automatic logic [STATUS_W-1:0] handle_verdict(input logic [HANDLE_W-1:0] h);
      logic [IDX_W-1:0] s;
      s = h[IDX_W-1:0];
      if (int'(s) >= tbl_size || h == '1) return ST_BAD_ID;
      if (!m_id[s][HANDLE_W-1]) return ST_CLOSED;
      if (m_id[s] != h) return ST_STALE;
      return ST_OK;
   endfunction

   // Applies one accepted request to the predicted table, returns the response
   function automatic rsp_type apply_to_table(input logic [FUNC_W-1:0]    fn,
                                              input logic [HANDLE_W-1:0]  h,
                                              input logic [PAYLOAD_W-1:0] pin,
                                              input logic [TRK_W-1:0]     trk);
      rsp_type          r;
      logic [IDX_W-1:0] s;
      int               i;
      r = '0;
      s = h[IDX_W-1:0];
      case (fn)
         FN_ALLOC: begin
            if (m_free_empty) begin
               r.status     = ST_LIST_EMPTY;
               r.handle_out = '1;
            end else begin
               s = m_free_head;
               // a self-linked slot is the tail of the free list
               if (m_link[s] == s) m_free_empty = 1'b1;
               else m_free_head = m_link[s];
               m_payload[s]          = pin;
               m_id[s][HANDLE_W-1]   = 1'b1;
               r.handle_out          = m_id[s];
            end
         end
         FN_LOOKUP: begin
            r.status = handle_verdict(h);
            if (r.status == ST_OK) r.payload_out = m_payload[s];
         end
         FN_RELEASE: begin
            r.status = handle_verdict(h);
            if (r.status == ST_OK) begin
               r.payload_out = m_payload[s];
               m_id[s]       = {1'b0, m_id[s][HANDLE_W-2:IDX_W] + 1'b1, s};
               m_link[s]     = m_free_empty ? s : m_free_head;
               m_free_head   = s;
               m_free_empty  = 1'b0;
            end
         end
         FN_SCAN_FIRST: begin
            i = 0;
            while (i < tbl_size && !m_id[i][HANDLE_W-1]) i++;
            r.tracker_out = TRK_W'(i);
         end
         FN_SCAN_NEXT: begin
            if (int'(trk) > tbl_size) begin
               r.status      = ST_PAST_END;
               r.tracker_out = trk;
            end else if (int'(trk) == tbl_size) begin
               r.tracker_out = trk + 1'b1;
            end else begin
               i = int'(trk);
               while (i < tbl_size && !m_id[i][HANDLE_W-1]) i++;
               if (i < tbl_size) begin
                  r.handle_out  = m_id[i];
                  r.payload_out = m_payload[i];
                  r.found       = 1'b1;
                  i++;
               end
               r.tracker_out = TRK_W'(i);
            end
         end
         default: r.status = ST_BAD_ID;
      endcase
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Directed table rows
   // -------------------------------------------------------------------------
   function automatic dir_row_type op_row(input logic [FUNC_W-1:0] fn,
                                          input logic [HANDLE_W-1:0] h,
                                          input logic [PAYLOAD_W-1:0] p,
                                          input logic [TRK_W-1:0] t);
      dir_row_type r;
      r          = '{kind: ROW_OP, default: '0};
      r.func     = fn;
      r.handle   = h;
      r.payload  = p;
      r.tracker  = t;
      return r;
   endfunction

   function automatic dir_row_type chk_row(input logic [FUNC_W-1:0] fn,
                                           input logic [HANDLE_W-1:0] h,
                                           input logic [PAYLOAD_W-1:0] p,
                                           input logic [TRK_W-1:0] t,
                                           input logic [STATUS_W-1:0] st,
                                           input logic [HANDLE_W-1:0] ho,
                                           input logic [PAYLOAD_W-1:0] po,
                                           input logic [TRK_W-1:0] tro,
                                           input logic fnd);
      dir_row_type r;
      r        = op_row(fn, h, p, t);
      r.typed  = 1'b1;
      r.golden = '{status: st, handle_out: ho, payload_out: po, tracker_out: tro, found: fnd};
      return r;
   endfunction

   function automatic dir_row_type size_row(input logic [CFG_W-1:0] v);
      dir_row_type r;
      r          = '{kind: ROW_SIZE, default: '0};
      r.size_val = v;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------

   // Offers one transaction and returns at the edge where it is accepted.
   // valid stays high on return so a back-to-back offer keeps the channel busy;
   // a gap lowers it in the step the previous transaction was taken.
   task automatic offer(input logic [FUNC_W-1:0]    fn,
                        input logic [HANDLE_W-1:0]  h,
                        input logic [PAYLOAD_W-1:0] p,
                        input logic [TRK_W-1:0]     t,
                        input bit                   typed,
                        input rsp_type              golden);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0 && gapless == 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      if (gapless != 0) gapless--;
      table_rsp_q.push_back('{typed: typed, rsp: golden});
      req_if.func       <= fn;
      req_if.handle     <= h;
      req_if.payload_in <= p;
      req_if.tracker_in <= t;
      req_if.valid      <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Always waits on a clock edge before checking, so later drives land in a new step
   task automatic wait_drained();
      do @(posedge clock); while (pending_rsp_q.size() != 0);
   endtask

   // table_size write, only with the block idle; the predictor is rebuilt alongside
   task automatic write_size(input logic [CFG_W-1:0] v);
      req_if.valid <= 1'b0;
      wait_drained();
      repeat (IDLE_PAUSE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rebuild_table(int'(v));
      burst_left = 0;
   endtask

   // Handle of some open slot, or a closed one when nothing is open
   function automatic logic [HANDLE_W-1:0] live_handle();
      int start;
      int i;
      start = $urandom_range(0, tbl_size - 1);
      for (int k = 0; k < tbl_size; k++) begin
         i = (start + k) % tbl_size;
         if (m_id[i][HANDLE_W-1]) return m_id[i];
      end
      return {1'b1, 23'($urandom()), IDX_W'(start)};
   endfunction

   // Unimplemented func code
   function automatic logic [FUNC_W-1:0] FN_FUNC_RAND();
      return FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
   endfunction

   // Mostly well-formed traffic against live handles, the rest malformed.
   // Reads the predicted table only to aim the stimulus; it does not change
   // the table.
   task automatic random_item(output logic [FUNC_W-1:0]    fn,
                              output logic [HANDLE_W-1:0]  h,
                              output logic [PAYLOAD_W-1:0] p,
                              output logic [TRK_W-1:0]     t);
      int                  r;
      int                  idx;
      logic [HANDLE_W-1:0] pick;
      r  = $urandom_range(0, 99);
      fn = FN_ALLOC;
      h  = $urandom();
      p  = $urandom();
      t  = TRK_W'($urandom_range(0, (1 << TRK_W) - 1));
      if (r < 30) begin
         fn = FN_ALLOC;
      end else if (r < 52) begin
         fn = FN_LOOKUP;
         h  = live_handle();
      end else if (r < 72) begin
         fn = FN_RELEASE;
         h  = live_handle();
         retired_q.push_back(h);
         if (retired_q.size() > 16) void'(retired_q.pop_front());
      end else if (r < 77) begin
         fn = FN_SCAN_FIRST;
      end else if (r < 87) begin
         fn = FN_SCAN_NEXT;
         case ($urandom_range(0, 5))
            0, 1: begin
               pick = live_handle();
               t    = TRK_W'(pick[IDX_W-1:0]);
            end
            2:       t = TRK_W'(tbl_size);
            3:       t = TRK_W'(tbl_size + 1);
            4:       t = TRK_W'($urandom_range(0, tbl_size));
            default: ;   // keep the full-range tracker
         endcase
      end else begin
         fn = $urandom_range(0, 1) ? FN_LOOKUP : FN_RELEASE;
         case ($urandom_range(0, 5))
            0:       ;   // arbitrary handle word
            1:       if (retired_q.size() != 0)
                        h = retired_q[$urandom_range(0, retired_q.size() - 1)];
            2:       h = '1;
            3: begin
               idx = $urandom_range(tbl_size, (1 << IDX_W) - 1);
               h   = {1'b1, 23'($urandom()), IDX_W'(idx)};
            end
            4:       fn = FN_FUNC_RAND();
            default: fn = FN_SCAN_NEXT;
         endcase
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus: reset, directed table, then randomized phases
   // -------------------------------------------------------------------------
   initial begin
      dir_row_type          dir_tab [$];
      logic [CFG_W-1:0]     sz;
      logic [FUNC_W-1:0]    fn;
      logic [HANDLE_W-1:0]  h;
      logic [PAYLOAD_W-1:0] p;
      logic [TRK_W-1:0]     t;

      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_if.valid      <= 1'b0;
      req_if.func       <= FN_ALLOC;
      req_if.handle     <= '0;
      req_if.payload_in <= '0;
      req_if.tracker_in <= '0;
      rebuild_table(RESET_SIZE);

      // After reset: 255 slots, free list 0,1,2,... Typed rows are the ones
      // whose answer follows directly from that; the rest go to the predictor.
      dir_tab = '{
         chk_row(FN_ALLOC, '0, '1, '0, ST_OK, 32'h8000_0000, '0, '0, 1'b0),
         chk_row(FN_ALLOC, '1, '0, '1, ST_OK, 32'h8000_0001, '0, '0, 1'b0),
         chk_row(FN_LOOKUP, 32'h8000_0000, '0, '0, ST_OK, '0, '1, '0, 1'b0),
         // all-ones handle, index past the table, closed slot, handle with open bit clear
         chk_row(FN_LOOKUP, '1, '0, '0, ST_BAD_ID, '0, '0, '0, 1'b0),
         chk_row(FN_LOOKUP, 32'h8000_00FF, '0, '0, ST_BAD_ID, '0, '0, '0, 1'b0),
         chk_row(FN_LOOKUP, 32'h8000_0002, '0, '0, ST_CLOSED, '0, '0, '0, 1'b0),
         chk_row(FN_LOOKUP, 32'h0000_0001, '0, '0, ST_STALE, '0, '0, '0, 1'b0),
         chk_row(FN_SCAN_FIRST, '0, '0, '1, ST_OK, '0, '0, '0, 1'b0),
         op_row(FN_SCAN_NEXT, '0, '0, 9'd1),
         op_row(FN_SCAN_NEXT, '0, '0, 9'd2),
         // tracker at table_size steps one past; beyond that is past the end
         chk_row(FN_SCAN_NEXT, '0, '0, 9'd255, ST_OK, '0, '0, 9'd256, 1'b0),
         chk_row(FN_SCAN_NEXT, '0, '0, 9'd511, ST_PAST_END, '0, '0, 9'd511, 1'b0),
         op_row(FN_RELEASE, 32'h8000_0000, '0, '0),
         chk_row(FN_RELEASE, 32'h8000_0000, '0, '0, ST_CLOSED, '0, '0, '0, 1'b0),
         op_row(FN_ALLOC, '0, 32'hA5A5_5A5A, '0),
         chk_row(FN_LOOKUP, 32'h8000_0000, '0, '0, ST_STALE, '0, '0, '0, 1'b0),
         chk_row(FN_UNUSED_HI, '1, '1, '1, ST_BAD_ID, '0, '0, '0, 1'b0),
         // size zero is raised to the minimum of three slots
         size_row(8'd0),
         chk_row(FN_ALLOC, '0, 32'h1, '0, ST_OK, 32'h8000_0000, '0, '0, 1'b0),
         op_row(FN_ALLOC, '0, 32'h2, '0),
         op_row(FN_ALLOC, '0, 32'h3, '0),
         chk_row(FN_ALLOC, '0, '0, '0, ST_LIST_EMPTY, '1, '0, '0, 1'b0),
         // push onto an empty free list, then pop it again
         op_row(FN_RELEASE, 32'h8000_0002, '0, '0),
         op_row(FN_ALLOC, '0, 32'hDEAD_BEEF, '0),
         chk_row(FN_ALLOC, '0, '0, '0, ST_LIST_EMPTY, '1, '0, '0, 1'b0),
         chk_row(FN_LOOKUP, 32'h8000_0003, '0, '0, ST_BAD_ID, '0, '0, '0, 1'b0),
         chk_row(FN_SCAN_NEXT, '0, '0, 9'd3, ST_OK, '0, '0, 9'd4, 1'b0),
         chk_row(FN_SCAN_NEXT, '0, '0, 9'd4, ST_PAST_END, '0, '0, 9'd4, 1'b0),
         size_row(8'hFF)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_SIZE) begin
            write_size(dir_tab[i].size_val);
         end else begin
            offer(dir_tab[i].func, dir_tab[i].handle, dir_tab[i].payload,
                  dir_tab[i].tracker, dir_tab[i].typed, dir_tab[i].golden);
         end
      end

      // Random phases; small tables empty the free list often, the largest
      // ones give long scans.
      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0:       sz = 8'd0;
            1:       sz = CFG_W'($urandom_range(4, 9));
            2:       sz = 8'hFF;
            3:       sz = 8'd1;
            4:       sz = CFG_W'($urandom_range(10, 32));
            5:       sz = 8'd3;
            6:       sz = CFG_W'($urandom_range(0, 255));
            default: sz = 8'd2;
         endcase
         write_size(sz);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off while transactions keep coming, no gaps
            if (ph == 2 && n == 20) begin
               long_hold_req = 1'b1;
               gapless       = 80;
            end
            // occasional full drain before continuing
            if (n % 150 == 149) begin
               req_if.valid <= 1'b0;
               wait_drained();
               burst_left = 0;
            end
            random_item(fn, h, p, t);
            offer(fn, h, p, t, 1'b0, '0);
         end
      end

      req_if.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: stall patterns in random stretches, one long hold on request
   // -------------------------------------------------------------------------
   initial begin
      int mode;
      int span;
      int tick;
      tick = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            repeat (LONG_HOLD) begin
               @(posedge clock);
               rsp_if.ready <= 1'b0;
            end
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= 1'($urandom_range(0, 1));
               2:       rsp_if.ready <= ($urandom_range(0, 7) != 0);
               default: rsp_if.ready <= tick[2];
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Prediction and checking. Request and response are handled in one process
   // so a response taken at the same edge as its request still finds its
   // expectation queued first.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type     want;
      rsp_type     got;
      rsp_tag_type tag;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            want = apply_to_table(req_if.func, req_if.handle, req_if.payload_in,
                                  req_if.tracker_in);
            tag  = table_rsp_q.pop_front();
            if (tag.typed) want = tag.rsp;
            pending_rsp_q.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.status      = rsp_if.status;
            got.handle_out  = rsp_if.handle_out;
            got.payload_out = rsp_if.payload_out;
            got.tracker_out = rsp_if.tracker_out;
            got.found       = rsp_if.found;
            if (pending_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response transaction: expected none, got %h",
                        $time, got);
            end else begin
               want = pending_rsp_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display({"%0t: response mismatch: expected st=%0d h=%h p=%h trk=%0d ",
                            "f=%0b, got st=%0d h=%h p=%h trk=%0d f=%0b"},
                           $time, want.status, want.handle_out, want.payload_out,
                           want.tracker_out, want.found, got.status, got.handle_out,
                           got.payload_out, got.tracker_out, got.found);
               end
            end
         end
      end
   end

   // Hard stop in case the block hangs
   initial begin
      #TIMEOUT;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
src/ght_pkg.sv
src/ght_if.sv
src/ght_ram.sv
src/ght_rsp_buf.sv
src/generational_handle_table_top.sv
tb/generational_handle_table_top_tb.sv
